[src/line_integral_convolution_macros.svh]
// assertion macros for the line integral convolution block
// used by the controller; no other dependencies
`ifndef LINE_INTEGRAL_CONVOLUTION_MACROS_SVH
`define LINE_INTEGRAL_CONVOLUTION_MACROS_SVH
`ifndef SYNTHESIS
`define LIC_ASSERT_IMP(lbl, ck, rn, a, b) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (b)) \
        else $error("lic check failed");
`define LIC_ASSERT_NXT(lbl, ck, rn, a, b) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (b)) \
        else $error("lic check failed");
`else
`define LIC_ASSERT_IMP(lbl, ck, rn, a, b)
`define LIC_ASSERT_NXT(lbl, ck, rn, a, b)
`endif
`endif

[src/lic_pkg.sv]
// shared types, constants and width helpers for the line integral convolution block
// no dependencies
`timescale 1ns / 1ps
package lic_pkg;

    localparam int FRAC       = 16;
    localparam int NOISE_W    = 16;
    localparam int M8_W       = 24;
    localparam int QUO_W      = 18;
    localparam int SQRT_STEPS = 24;
    localparam int DIV_STEPS  = 18;
    localparam int ITER_W     = 5;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_LENGTH = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE     = 8'd3;

    function automatic int dim_bits(input int mw, input int mh);
        int m;
        m = (mw > mh) ? mw : mh;
        return ($clog2(m + 1) > 9) ? $clog2(m + 1) : 9;
    endfunction

    function automatic int klen_bits(input int mk);
        return ($clog2(mk + 1) > 7) ? $clog2(mk + 1) : 7;
    endfunction

    typedef struct packed {
        logic accept;
        logic query_init;
        logic rd_own;
        logic own_cap;
        logic dir_fwd;
        logic acc;
        logic mul;
        logic sqrt_step;
        logic div_init;
        logic div_step;
        logic advance;
        logic fin_init;
        logic emit;
        logic emit_oor;
    } lic_cmd_t;

    typedef struct packed {
        logic oor;
        logic stop;
        logic vel_zero;
        logic dir_back;
    } lic_sts_t;

endpackage

[src/lic_cfg.sv]
// configuration registers with saturation of size and kernel length
// depends on lic_pkg
`timescale 1ns / 1ps
module lic_cfg #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_KERNEL = 64
) (
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  logic                                                   cfg_valid,
    input  logic [lic_pkg::CFG_IDX_W-1:0]                          cfg_index,
    input  logic [lic_pkg::CFG_DATA_W-1:0]                         cfg_data,
    output logic [lic_pkg::dim_bits(MAX_WIDTH, MAX_HEIGHT)-1:0]    w_eff,
    output logic [lic_pkg::dim_bits(MAX_WIDTH, MAX_HEIGHT)-1:0]    h_eff,
    output logic [lic_pkg::klen_bits(MAX_KERNEL)-1:0]              klen_eff,
    output logic [9:0]                                             step_size
);
    import lic_pkg::*;

    localparam int DW = dim_bits(MAX_WIDTH, MAX_HEIGHT);
    localparam int KW = klen_bits(MAX_KERNEL);

    logic [8:0] width_reg;
    logic [8:0] height_reg;
    logic [6:0] kernel_reg;
    logic [9:0] step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
            kernel_reg <= 7'd20;
            step_reg   <= 10'd256;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:   width_reg  <= cfg_data[8:0];
                REG_IMAGE_HEIGHT:  height_reg <= cfg_data[8:0];
                REG_KERNEL_LENGTH: kernel_reg <= cfg_data[6:0];
                REG_STEP_SIZE:     step_reg   <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg < 9'd2)
            w_eff = DW'(2);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = DW'(MAX_WIDTH);
        else
            w_eff = DW'(width_reg);

        if (height_reg < 9'd2)
            h_eff = DW'(2);
        else if (32'(height_reg) > MAX_HEIGHT)
            h_eff = DW'(MAX_HEIGHT);
        else
            h_eff = DW'(height_reg);

        if (32'(kernel_reg) > MAX_KERNEL)
            klen_eff = KW'(MAX_KERNEL);
        else
            klen_eff = KW'(kernel_reg);
    end

    assign step_size = step_reg;

endmodule

[src/lic_dp.sv]
// datapath: pixel stores, trace position, magnitude root, step dividers, output register
// depends on lic_pkg
`timescale 1ns / 1ps
module lic_dp #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_KERNEL = 64
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  lic_pkg::lic_cmd_t                                   cmd,
    output lic_pkg::lic_sts_t                                   sts,
    input  logic                                                mode,
    input  logic [7:0]                                          pixel_x,
    input  logic [7:0]                                          pixel_y,
    input  logic [15:0]                                         noise_value,
    input  logic signed [15:0]                                  vel_x,
    input  logic signed [15:0]                                  vel_y,
    input  logic [lic_pkg::dim_bits(MAX_WIDTH, MAX_HEIGHT)-1:0] w_eff,
    input  logic [lic_pkg::dim_bits(MAX_WIDTH, MAX_HEIGHT)-1:0] h_eff,
    input  logic [lic_pkg::klen_bits(MAX_KERNEL)-1:0]           klen_eff,
    input  logic [9:0]                                          step_size,
    output logic                                                result_valid,
    output logic [7:0]                                          intensity,
    output logic [7:0]                                          sample_count,
    output logic                                                out_of_range
);
    import lic_pkg::*;

    localparam int DW    = dim_bits(MAX_WIDTH, MAX_HEIGHT);
    localparam int KW    = klen_bits(MAX_KERNEL);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = DW + FRAC + 3;
    localparam int PQ    = PW - FRAC;
    localparam int CW    = $clog2(2 * MAX_KERNEL + 1);
    localparam int SW    = NOISE_W + CW;
    localparam int HALF  = 1 << (FRAC - 1);
    localparam logic signed [PW-1:0] HALF_P   = PW'(HALF);
    localparam logic signed [PW-1:0] NEG_HALF = PW'(-HALF);

    logic [15:0] noise_mem [DEPTH];
    logic [31:0] vel_mem [DEPTH];

    logic [15:0]           rd_noise_reg;
    logic [31:0]           rd_vel_reg;
    logic [7:0]            qx_reg, qy_reg;
    logic [15:0]           own_reg;
    logic signed [PW-1:0]  px_reg, py_reg;
    logic [KW-1:0]         step_reg;
    logic                  dir_back_reg;
    logic [SW-1:0]         sum_reg;
    logic [CW-1:0]         cnt_reg;
    logic [15:0]           ax_reg, ay_reg;
    logic                  vx_neg_reg, vy_neg_reg;
    logic [47:0]           sq_n_reg;
    logic [25:0]           sq_rem_reg;
    logic [M8_W-1:0]       root_reg;
    logic [25:0]           numx_reg, numy_reg;
    logic [M8_W-1:0]       remx_reg, remy_reg;
    logic [QUO_W-1:0]      dqx_reg, dqy_reg;
    logic [M8_W-1:0]       dvx_reg;
    logic                  valid_reg;
    logic [7:0]            inten_reg, scount_reg;
    logic                  oor_reg;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr, own_addr, trace_addr, rd_addr;
    logic signed [PW-1:0]  rxx, rxy;
    logic [PQ-1:0]         ix_full, iy_full;
    logic [DW-1:0]         ix, iy;
    logic                  x_out, y_out;
    logic [25:0]           sq_sh, sq_trial;
    logic                  sq_ge;
    logic [M8_W:0]         dx_sh, dy_sh, dx_sub, dy_sub;
    logic                  dx_ge, dy_ge;
    logic [SW-1:0]         fin_base;
    logic [SW+7:0]         fin_prod;
    logic [41:0]           fin_num;
    logic [PW-1:0]         qxe, qye;

    // stores, one write port for loads and one registered read port
    assign wr_en = cmd.accept && !mode && (int'(pixel_x) < MAX_WIDTH)
                   && (int'(pixel_y) < MAX_HEIGHT);
    assign wr_addr    = AW'(pixel_y) * AW'(MAX_WIDTH) + AW'(pixel_x);
    assign own_addr   = AW'(qy_reg) * AW'(MAX_WIDTH) + AW'(qx_reg);
    assign trace_addr = AW'(iy) * AW'(MAX_WIDTH) + AW'(ix);
    assign rd_addr    = cmd.rd_own ? own_addr : trace_addr;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            noise_mem[wr_addr] <= noise_value;
            vel_mem[wr_addr]   <= {vel_y, vel_x};
        end
        rd_noise_reg <= noise_mem[rd_addr];
        rd_vel_reg   <= vel_mem[rd_addr];
    end

    // round half away from zero; anything at or below minus one half is off the image
    always_comb
    begin
        rxx     = px_reg + HALF_P;
        rxy     = py_reg + HALF_P;
        ix_full = rxx[PW-1:FRAC];
        iy_full = rxy[PW-1:FRAC];
        x_out   = px_reg[PW-1] ? (px_reg <= NEG_HALF) : (ix_full >= PQ'(w_eff));
        y_out   = py_reg[PW-1] ? (py_reg <= NEG_HALF) : (iy_full >= PQ'(h_eff));
        ix      = px_reg[PW-1] ? '0 : ix_full[DW-1:0];
        iy      = py_reg[PW-1] ? '0 : iy_full[DW-1:0];
    end

    assign sts.oor      = (DW'(qx_reg) >= w_eff) || (DW'(qy_reg) >= h_eff);
    assign sts.stop     = (step_reg == klen_eff) || x_out || y_out;
    assign sts.vel_zero = (rd_vel_reg == '0);
    assign sts.dir_back = dir_back_reg;

    // one root bit per beat
    assign sq_sh    = {sq_rem_reg[23:0], sq_n_reg[47:46]};
    assign sq_trial = {root_reg, 2'b01};
    assign sq_ge    = (sq_sh >= sq_trial);

    // restoring dividers, one quotient bit per beat
    assign dx_sh  = {remx_reg, dqx_reg[QUO_W-1]};
    assign dy_sh  = {remy_reg, dqy_reg[QUO_W-1]};
    assign dx_sub = dx_sh - {1'b0, dvx_reg};
    assign dy_sub = dy_sh - {1'b0, root_reg};
    assign dx_ge  = (dx_sh >= {1'b0, dvx_reg});
    assign dy_ge  = (dy_sh >= {1'b0, root_reg});

    // mean scaling: floor(sum*255/65536) then divided by the count; with no samples, the pixel's own noise over one
    assign fin_base = (cnt_reg == '0) ? SW'(own_reg) : sum_reg;
    assign fin_prod = (SW+8)'(fin_base) * (SW+8)'(255);
    assign fin_num  = 42'(fin_prod[SW+7:FRAC]);

    assign qxe = PW'(dqx_reg);
    assign qye = PW'(dqy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_back_reg <= 1'b1;
            valid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.query_init)
                dir_back_reg <= 1'b1;
            else if (cmd.dir_fwd)
                dir_back_reg <= 1'b0;
            valid_reg <= cmd.emit || cmd.emit_oor;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            qx_reg <= pixel_x;
            qy_reg <= pixel_y;
        end
        if (cmd.own_cap)
            own_reg <= rd_noise_reg;
        if (cmd.query_init || cmd.dir_fwd)
        begin
            px_reg   <= PW'({qx_reg, {FRAC{1'b0}}});
            py_reg   <= PW'({qy_reg, {FRAC{1'b0}}});
            step_reg <= '0;
        end
        else if (cmd.advance)
        begin
            px_reg   <= (vx_neg_reg ^ dir_back_reg) ? px_reg - qxe : px_reg + qxe;
            py_reg   <= (vy_neg_reg ^ dir_back_reg) ? py_reg - qye : py_reg + qye;
            step_reg <= step_reg + KW'(1);
        end
        if (cmd.query_init)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.acc)
        begin
            sum_reg <= sum_reg + SW'(rd_noise_reg);
            cnt_reg <= cnt_reg + CW'(1);
        end
        if (cmd.acc)
        begin
            ax_reg     <= rd_vel_reg[15] ? (~rd_vel_reg[15:0] + 16'd1) : rd_vel_reg[15:0];
            ay_reg     <= rd_vel_reg[31] ? (~rd_vel_reg[31:16] + 16'd1) : rd_vel_reg[31:16];
            vx_neg_reg <= rd_vel_reg[15];
            vy_neg_reg <= rd_vel_reg[31];
        end
        if (cmd.mul)
        begin
            sq_n_reg   <= {32'(ax_reg) * 32'(ax_reg) + 32'(ay_reg) * 32'(ay_reg), 16'b0};
            sq_rem_reg <= '0;
            root_reg   <= '0;
            numx_reg   <= 26'(step_size) * 26'(ax_reg);
            numy_reg   <= 26'(step_size) * 26'(ay_reg);
        end
        else if (cmd.sqrt_step)
        begin
            sq_n_reg   <= {sq_n_reg[45:0], 2'b00};
            sq_rem_reg <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
            root_reg   <= {root_reg[M8_W-2:0], sq_ge};
        end
        if (cmd.div_init)
        begin
            remx_reg <= numx_reg[25:2];
            dqx_reg  <= {numx_reg[1:0], 16'b0};
            remy_reg <= numy_reg[25:2];
            dqy_reg  <= {numy_reg[1:0], 16'b0};
            dvx_reg  <= root_reg;
        end
        else if (cmd.fin_init)
        begin
            remx_reg <= fin_num[41:QUO_W];
            dqx_reg  <= fin_num[QUO_W-1:0];
            dvx_reg  <= (cnt_reg == '0) ? M8_W'(1) : M8_W'(cnt_reg);
        end
        else if (cmd.div_step)
        begin
            remx_reg <= dx_ge ? dx_sub[M8_W-1:0] : dx_sh[M8_W-1:0];
            dqx_reg  <= {dqx_reg[QUO_W-2:0], dx_ge};
            remy_reg <= dy_ge ? dy_sub[M8_W-1:0] : dy_sh[M8_W-1:0];
            dqy_reg  <= {dqy_reg[QUO_W-2:0], dy_ge};
        end
        if (cmd.emit)
        begin
            inten_reg  <= (dqx_reg > QUO_W'(255)) ? 8'd255 : dqx_reg[7:0];
            scount_reg <= (32'(cnt_reg) > 255) ? 8'd255 : 8'(cnt_reg);
            oor_reg    <= 1'b0;
        end
        else if (cmd.emit_oor)
        begin
            inten_reg  <= 8'd0;
            scount_reg <= 8'd0;
            oor_reg    <= 1'b1;
        end
    end

    assign result_valid = valid_reg;
    assign intensity    = inten_reg;
    assign sample_count = scount_reg;
    assign out_of_range = oor_reg;

endmodule

[src/lic_ctrl.sv]
// controller state machine sequencing loads, traces, root and divider beats
// depends on lic_pkg and line_integral_convolution_macros.svh
`timescale 1ns / 1ps
`include "line_integral_convolution_macros.svh"
module lic_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              mode,
    output logic              busy,
    output lic_pkg::lic_cmd_t cmd,
    input  lic_pkg::lic_sts_t sts
);
    import lic_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_CHK  = 14'b00000000000010,
        S_OWN  = 14'b00000000000100,
        S_TEST = 14'b00000000001000,
        S_ACC  = 14'b00000000010000,
        S_MUL  = 14'b00000000100000,
        S_SQRT = 14'b00000001000000,
        S_DIVI = 14'b00000010000000,
        S_DIV  = 14'b00000100000000,
        S_ADV  = 14'b00001000000000,
        S_FIN  = 14'b00010000000000,
        S_FDIV = 14'b00100000000000,
        S_EMIT = 14'b01000000000000,
        S_OOR  = 14'b10000000000000
    } state_t;

    state_t              state_reg, state_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        iter_next  = iter_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    if (mode)
                        state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                cmd.rd_own     = 1'b1;
                cmd.query_init = 1'b1;
                state_next     = sts.oor ? S_OOR : S_OWN;
            end
            S_OWN:
            begin
                cmd.own_cap = 1'b1;
                state_next  = S_TEST;
            end
            S_TEST:
            begin
                if (sts.stop)
                begin
                    // backward trace done: restart forward from the pixel
                    if (sts.dir_back)
                        cmd.dir_fwd = 1'b1;
                    else
                        state_next = S_FIN;
                end
                else
                    state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc = 1'b1;
                if (sts.vel_zero)
                begin
                    if (sts.dir_back)
                    begin
                        cmd.dir_fwd = 1'b1;
                        state_next  = S_TEST;
                    end
                    else
                        state_next = S_FIN;
                end
                else
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                iter_next  = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (iter_reg == ITER_W'(SQRT_STEPS - 1))
                begin
                    iter_next  = '0;
                    state_next = S_DIVI;
                end
                else
                    iter_next = iter_reg + ITER_W'(1);
            end
            S_DIVI:
            begin
                cmd.div_init = 1'b1;
                iter_next    = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (iter_reg == ITER_W'(DIV_STEPS - 1))
                begin
                    iter_next  = '0;
                    state_next = S_ADV;
                end
                else
                    iter_next = iter_reg + ITER_W'(1);
            end
            S_ADV:
            begin
                cmd.advance = 1'b1;
                state_next  = S_TEST;
            end
            S_FIN:
            begin
                cmd.fin_init = 1'b1;
                iter_next    = '0;
                state_next   = S_FDIV;
            end
            S_FDIV:
            begin
                cmd.div_step = 1'b1;
                if (iter_reg == ITER_W'(DIV_STEPS - 1))
                begin
                    iter_next  = '0;
                    state_next = S_EMIT;
                end
                else
                    iter_next = iter_reg + ITER_W'(1);
            end
            S_EMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
            end
            S_OOR:
            begin
                cmd.emit_oor = 1'b1;
                state_next   = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    `LIC_ASSERT_NXT(a_emit_idle, clk, rst_n, cmd.emit || cmd.emit_oor, state_reg == S_IDLE)
    `LIC_ASSERT_NXT(a_root_len, clk, rst_n, (state_reg == S_SQRT) && (iter_reg == ITER_W'(SQRT_STEPS - 1)), state_reg == S_DIVI)
    `LIC_ASSERT_NXT(a_query_busy, clk, rst_n, cmd.accept && mode, busy)
    `LIC_ASSERT_IMP(a_div_iter, clk, rst_n, (state_reg == S_DIV) || (state_reg == S_FDIV), iter_reg < ITER_W'(DIV_STEPS))

endmodule

[src/line_integral_convolution.sv]
// top level of the line integral convolution block
// depends on lic_pkg, lic_cfg, lic_ctrl and lic_dp
//
// channel   direction  handshake             payload
// command   in         start, busy           mode, pixel_x, pixel_y, noise_value, vel_x, vel_y
// config    in         cfg_valid, cfg_ready  cfg_index, cfg_data
// result    out        result_valid strobe   intensity, sample_count, out_of_range
//
// a load gives no result; busy stays low
// a query's length is set by the magnitude root and the step divider,
// which run once for every trace step
// result_valid is high for one cycle, in the cycle in which busy falls
// reset is asynchronous and active low; the stores are not cleared
// results cannot be held off; cfg_ready is always high
`timescale 1ns / 1ps
module line_integral_convolution #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_KERNEL = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              mode,
    input  logic [7:0]                        pixel_x,
    input  logic [7:0]                        pixel_y,
    input  logic [15:0]                       noise_value,
    input  logic signed [15:0]                vel_x,
    input  logic signed [15:0]                vel_y,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lic_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lic_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              result_valid,
    output logic [7:0]                        intensity,
    output logic [7:0]                        sample_count,
    output logic                              out_of_range
);
    import lic_pkg::*;

    localparam int DW = dim_bits(MAX_WIDTH, MAX_HEIGHT);
    localparam int KW = klen_bits(MAX_KERNEL);

    lic_cmd_t       cmd;
    lic_sts_t       sts;
    logic [DW-1:0]  w_eff, h_eff;
    logic [KW-1:0]  klen_eff;
    logic [9:0]     step_size;

    assign cfg_ready = 1'b1;

    lic_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .w_eff     (w_eff),
        .h_eff     (h_eff),
        .klen_eff  (klen_eff),
        .step_size (step_size)
    );

    lic_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .busy  (busy),
        .cmd   (cmd),
        .sts   (sts)
    );

    lic_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .mode         (mode),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .noise_value  (noise_value),
        .vel_x        (vel_x),
        .vel_y        (vel_y),
        .w_eff        (w_eff),
        .h_eff        (h_eff),
        .klen_eff     (klen_eff),
        .step_size    (step_size),
        .result_valid (result_valid),
        .intensity    (intensity),
        .sample_count (sample_count),
        .out_of_range (out_of_range)
    );

endmodule

[sim/line_integral_convolution_tb.sv]
// self-checking testbench for line_integral_convolution: loads, queries and register writes
// with an in-bench predictor of the traced intensity; depends on lic_pkg and the block itself
`timescale 1ns / 1ps
module line_integral_convolution_tb;
    import lic_pkg::*;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd9;
    localparam int STORE_W = 256;
    localparam int STORE_H = 256;
    localparam int KERN_MAX = 64;
    localparam int PRE_SIDE = 20;

    typedef struct packed {
        logic [7:0] inten;
        logic [7:0] cnt;
        logic       oor;
    } lic_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  mode;
    logic [7:0]            pixel_x;
    logic [7:0]            pixel_y;
    logic [15:0]           noise_value;
    logic signed [15:0]    vel_x;
    logic signed [15:0]    vel_y;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  result_valid;
    logic [7:0]            intensity;
    logic [7:0]            sample_count;
    logic                  out_of_range;

    // predictor copy of registers and stores
    logic [8:0]  img_w;
    logic [8:0]  img_h;
    logic [6:0]  kern_len;
    logic [9:0]  step_len;
    logic [15:0] noise_mem [STORE_W*STORE_H];
    logic [31:0] vel_mem   [STORE_W*STORE_H];
    bit          written   [STORE_W*STORE_H];

    lic_result_t pending_results [$];
    int          mismatches;
    int          loads_sent;
    int          queries_sent;
    int          results_seen;
    int          sender_idle_pct;

    line_integral_convolution dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .noise_value  (noise_value),
        .vel_x        (vel_x),
        .vel_y        (vel_y),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .intensity    (intensity),
        .sample_count (sample_count),
        .out_of_range (out_of_range)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned probe;
        root = 0;
        probe = 64'd1 << 62;
        while (probe > n)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (n >= root + probe)
            begin
                n = n - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root = root >> 1;
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic longint round_half_away(input longint p);
        if (p >= 0)
            return (p + 32768) >>> 16;
        return -(((-p) + 32768) >>> 16);
    endfunction

    function automatic longint axis_delta(input longint v, input longint unsigned mag,
                                          input int dir);
        longint unsigned a;
        longint unsigned q;
        a = (v < 0) ? -v : v;
        q = ((longint'(step_len) * a) << 16) / mag;
        return ((v < 0) != (dir < 0)) ? -longint'(q) : longint'(q);
    endfunction

    // miss names the first unwritten entry the query would read, or -1
    function automatic lic_result_t convolve_pixel(input logic [7:0] qx, input logic [7:0] qy,
                                                   output int miss);
        lic_result_t     r;
        int              w;
        int              h;
        int              klen;
        longint          px;
        longint          py;
        longint          ix;
        longint          iy;
        longint          vx;
        longint          vy;
        longint unsigned mag;
        longint unsigned sum;
        longint unsigned inten;
        int              count;
        int              addr;
        int              own;
        miss = -1;
        w = (img_w < 2) ? 2 : ((img_w > STORE_W) ? STORE_W : img_w);
        h = (img_h < 2) ? 2 : ((img_h > STORE_H) ? STORE_H : img_h);
        klen = (kern_len > KERN_MAX) ? KERN_MAX : kern_len;
        r = '0;
        if (qx >= w || qy >= h)
        begin
            r.oor = 1'b1;
            return r;
        end
        sum = 0;
        count = 0;
        for (int dir = -1; dir <= 1; dir += 2)
        begin
            px = longint'(qx) << 16;
            py = longint'(qy) << 16;
            for (int s = 0; s < klen; s++)
            begin
                ix = round_half_away(px);
                iy = round_half_away(py);
                if (ix < 0 || ix >= w || iy < 0 || iy >= h)
                    break;
                addr = int'(iy) * STORE_W + int'(ix);
                if (!written[addr])
                begin
                    miss = addr;
                    return r;
                end
                sum += noise_mem[addr];
                count++;
                vx = longint'($signed(vel_mem[addr][15:0]));
                vy = longint'($signed(vel_mem[addr][31:16]));
                if (vx == 0 && vy == 0)
                    break;
                mag = int_sqrt(longint'(vx * vx + vy * vy) << 16);
                px += axis_delta(vx, mag, dir);
                py += axis_delta(vy, mag, dir);
            end
        end
        if (count > 0)
            inten = (sum * 255) / (longint'(count) << 16);
        else
        begin
            own = qy * STORE_W + qx;
            if (!written[own])
                miss = own;
            inten = (longint'(noise_mem[own]) * 255) >> 16;
        end
        r.inten = (inten > 255) ? 8'd255 : inten[7:0];
        r.cnt = (count > 255) ? 8'd255 : count[7:0];
        return r;
    endfunction

    // one command beat; the prediction is made after the accepting edge, once busy is low
    task automatic drive_item(input logic m, input logic [7:0] x, input logic [7:0] y,
                              input logic [15:0] nz, input logic [15:0] vx,
                              input logic [15:0] vy, input bit allow_gap);
        lic_result_t r;
        int          miss;
        if (allow_gap)
        begin
            while ($urandom_range(99) < sender_idle_pct)
            begin
                @(negedge clk);
                start = 1'b0;
            end
        end
        @(negedge clk);
        start = 1'b1;
        mode = m;
        pixel_x = x;
        pixel_y = y;
        noise_value = nz;
        vel_x = vx;
        vel_y = vy;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (m == MODE_LOAD)
        begin
            noise_mem[y * STORE_W + x] = nz;
            vel_mem[y * STORE_W + x] = {vy, vx};
            written[y * STORE_W + x] = 1'b1;
            loads_sent++;
        end
        else
        begin
            r = convolve_pixel(x, y, miss);
            pending_results.push_back(r);
            queries_sent++;
        end
    endtask

    // a query whose trace would reach an unwritten pixel gets that pixel loaded first,
    // with zero velocity so the trace ends there
    task automatic send_item(input logic m, input logic [7:0] x, input logic [7:0] y,
                             input logic [15:0] nz, input logic [15:0] vx,
                             input logic [15:0] vy, input bit allow_gap);
        lic_result_t r;
        int          miss;
        if (m == MODE_QUERY)
        begin
            r = convolve_pixel(x, y, miss);
            while (miss >= 0)
            begin
                drive_item(MODE_LOAD, 8'(miss % STORE_W), 8'(miss / STORE_W),
                           16'($urandom), 16'h0000, 16'h0000, allow_gap);
                r = convolve_pixel(x, y, miss);
            end
        end
        drive_item(m, x, y, nz, vx, vy, allow_gap);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        logic [15:0] data;
        data = 16'(value);
        // junk above the register width must be dropped
        case (idx)
            REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT: data[15:9] = 7'($urandom);
            REG_KERNEL_LENGTH:                 data[15:7] = 9'($urandom);
            REG_STEP_SIZE:                     data[15:10] = 6'($urandom);
            default:                           data = 16'($urandom);
        endcase
        wait_idle();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_IMAGE_WIDTH:   img_w = data[8:0];
            REG_IMAGE_HEIGHT:  img_h = data[8:0];
            REG_KERNEL_LENGTH: kern_len = data[6:0];
            REG_STEP_SIZE:     step_len = data[9:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [15:0] pick_velocity();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'h8000;
            2: return 16'h7fff;
            3: return 16'($signed($urandom_range(8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int pick_dim();
        case ($urandom_range(9))
            0: return 0;
            1: return 2;
            2: return 256;
            3: return 511;
            4: return $urandom_range(257, 510);
            default: return $urandom_range(3, PRE_SIDE);
        endcase
    endfunction

    // one corner of the store is written up front
    task automatic preload_stores();
        for (int i = 0; i < PRE_SIDE * PRE_SIDE; i++)
            send_item(MODE_LOAD, 8'(i % PRE_SIDE), 8'(i / PRE_SIDE), 16'($urandom),
                      pick_velocity(), pick_velocity(), 1'b0);
    endtask

    task automatic test_directed();
        write_reg(REG_KERNEL_LENGTH, 4);
        send_item(MODE_LOAD, 8'd0, 8'd0, 16'hffff, 16'h7fff, 16'h0000, 1'b0);
        send_item(MODE_LOAD, 8'd1, 8'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_item(MODE_LOAD, 8'd255, 8'd255, 16'hffff, 16'h8000, 16'h8000, 1'b0);
        send_item(MODE_LOAD, 8'd254, 8'd254, 16'h8000, 16'h7fff, 16'h7fff, 1'b0);
        send_item(MODE_QUERY, 8'd0, 8'd0, 16'hffff, 16'hffff, 16'hffff, 1'b0);
        send_item(MODE_QUERY, 8'd255, 8'd255, 16'h0, 16'h0, 16'h0, 1'b0);
        send_item(MODE_QUERY, 8'd1, 8'd0, 16'h0, 16'h0, 16'h0, 1'b0);
        // zero kernel length gives the pixel's own noise
        write_reg(REG_KERNEL_LENGTH, 0);
        send_item(MODE_QUERY, 8'd0, 8'd0, 16'h0, 16'h0, 16'h0, 1'b0);
        send_item(MODE_QUERY, 8'd254, 8'd254, 16'h0, 16'h0, 16'h0, 1'b0);
        // queries at and outside the edges of the configured slice
        write_reg(REG_IMAGE_WIDTH, 10);
        write_reg(REG_IMAGE_HEIGHT, 2);
        send_item(MODE_QUERY, 8'd10, 8'd0, 16'h0, 16'h0, 16'h0, 1'b0);
        send_item(MODE_QUERY, 8'd3, 8'd2, 16'h0, 16'h0, 16'h0, 1'b0);
        send_item(MODE_QUERY, 8'd9, 8'd1, 16'h0, 16'h0, 16'h0, 1'b0);
        write_reg(REG_UNUSED, 16'h1234);
        send_item(MODE_QUERY, 8'd255, 8'd0, 16'h0, 16'h0, 16'h0, 1'b0);
    endtask

    task automatic test_config_extremes();
        // sizes below two and above the store saturate, kernel saturates to its max
        write_reg(REG_IMAGE_WIDTH, 0);
        write_reg(REG_IMAGE_HEIGHT, 1);
        write_reg(REG_KERNEL_LENGTH, 127);
        write_reg(REG_STEP_SIZE, 1023);
        for (int i = 0; i < 3; i++)
            send_item(MODE_QUERY, 8'($urandom_range(2)), 8'($urandom_range(2)),
                      16'h0, 16'h0, 16'h0, 1'b0);
        write_reg(REG_IMAGE_WIDTH, 511);
        write_reg(REG_IMAGE_HEIGHT, 256);
        write_reg(REG_KERNEL_LENGTH, 64);
        write_reg(REG_STEP_SIZE, 0);
        send_item(MODE_QUERY, 8'd128, 8'd128, 16'h0, 16'h0, 16'h0, 1'b0);
        write_reg(REG_STEP_SIZE, 1);
        send_item(MODE_QUERY, 8'd255, 8'd17, 16'h0, 16'h0, 16'h0, 1'b0);
    endtask

    task automatic test_random(input int n_items, input int idle_pct);
        int left;
        int in_seg;
        int w;
        int h;
        sender_idle_pct = idle_pct;
        left = n_items;
        while (left > 0)
        begin
            w = pick_dim();
            h = pick_dim();
            write_reg(REG_IMAGE_WIDTH, w);
            write_reg(REG_IMAGE_HEIGHT, h);
            write_reg(REG_KERNEL_LENGTH, ($urandom_range(9) == 0) ? 64 + $urandom_range(63)
                                                                  : $urandom_range(12));
            write_reg(REG_STEP_SIZE, ($urandom_range(4) == 0) ? $urandom_range(1023)
                                                             : $urandom_range(64, 400));
            in_seg = (left < 45) ? left : 45;
            left -= in_seg;
            repeat (in_seg)
            begin
                // loads anywhere in the store, queries mostly inside the slice
                if ($urandom_range(99) < 65)
                    send_item(MODE_LOAD, 8'($urandom), 8'($urandom), 16'($urandom),
                              pick_velocity(), pick_velocity(), 1'b1);
                else if ($urandom_range(9) == 0)
                    send_item(MODE_QUERY, 8'($urandom), 8'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom), 1'b1);
                else
                    send_item(MODE_QUERY, 8'($urandom_range((w < 2) ? 1 : ((w > 256) ? 255
                              : w - 1))), 8'($urandom_range((h < 2) ? 1 : ((h > 256) ? 255
                              : h - 1))), 16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
            end
        end
    endtask

    always @(posedge clk)
    begin
        lic_result_t got;
        lic_result_t want;
        if (rst_n && result_valid)
        begin
            got = '{intensity, sample_count, out_of_range};
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: intensity %0d count %0d oor %0b",
                             intensity, sample_count, out_of_range);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %0d/%0d/%0b got %0d/%0d/%0b",
                                 want.inten, want.cnt, want.oor,
                                 intensity, sample_count, out_of_range);
                end
            end
        end
    end

    initial
    begin
        #200ms;
        $display("line_integral_convolution_tb: done, errors");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        mode = MODE_LOAD;
        pixel_x = '0;
        pixel_y = '0;
        noise_value = '0;
        vel_x = '0;
        vel_y = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        img_w = 9'd256;
        img_h = 9'd256;
        kern_len = 7'd20;
        step_len = 10'd256;
        mismatches = 0;
        loads_sent = 0;
        queries_sent = 0;
        results_seen = 0;
        sender_idle_pct = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        preload_stores();
        test_directed();
        test_config_extremes();
        test_random(220, 13);
        test_random(220, 53);
        test_random(220, 0);

        wait_idle();
        repeat (50) @(posedge clk);
        $display("covered %0d loads and %0d queries, %0d result beats checked",
                 loads_sent, queries_sent, results_seen);
        $display("%0d mismatches, %0d results still pending",
                 mismatches, pending_results.size());
        if (mismatches == 0 && pending_results.size() == 0)
            $display("line_integral_convolution_tb: done, clean");
        else
            $display("line_integral_convolution_tb: done, errors");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/lic_pkg.sv
src/lic_cfg.sv
src/lic_dp.sv
src/lic_ctrl.sv
src/line_integral_convolution.sv
sim/line_integral_convolution_tb.sv
